// ===== hw/rtl/jtdb_pkg.sv =====
// Shared types and constants for the JTAG to bus DMA bridge.
package jtdb_pkg;

   localparam int unsigned IncWindowBitsDefault = 10;
   localparam int unsigned AdrRegBits           = 35;
   localparam int unsigned DatRegBits           = 33;
   localparam int unsigned BusBits              = 32;
   localparam int unsigned WriteBit             = 34;

   // Transfer phases, one-hot.
   typedef enum logic [2:0] {
      PH_SHIFT = 3'b001,
      PH_BUS   = 3'b010,
      PH_NEXT  = 3'b100
   } phase_type;

   // One sample of the TAP signals and the DMA handshake.
   typedef struct packed {
      logic                bridge_reset_n;
      logic                tck;
      logic                tdi;
      logic                adr_sel;
      logic                data_sel;
      logic                shift_dr;
      logic                update_dr;
      logic                tap_reset;
      logic                dma_active;
      logic                dma_ready;
      logic [BusBits-1:0]  dma_rdata;
   } req_type;

   // Bridge outputs seen for one sample.
   typedef struct packed {
      logic                tdo;
      logic [BusBits-1:0]  dma_address;
      logic [BusBits-1:0]  dma_wdata;
      logic                dma_start;
      logic                dma_write;
      logic [1:0]          dma_size;
   } rsp_type;

endpackage

// ===== hw/rtl/jtdb_core.sv =====
// Bridge state: synchronisers, shift registers, phase sequencer and address increment.
module jtdb_core #(
   parameter int unsigned IncWindowBits = jtdb_pkg::IncWindowBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  jtdb_pkg::req_type req,
   output jtdb_pkg::rsp_type rsp
);
   import jtdb_pkg::*;

   logic [2:0]            tck_sync_ff, tdi_sync_ff, shift_sync_ff, update_sync_ff;
   logic [1:0]            reset_sync_ff, adrsel_sync_ff, datasel_sync_ff;
   phase_type             phase_ff, phase_in;
   logic [AdrRegBits-1:0] adr_ff, adr_in, adr_inc;
   logic [DatRegBits-1:0] dat_ff, dat_in;
   logic                  seq_ff, seq_in;
   logic [IncWindowBits-1:0] win_inc;

   logic wr, tck_rise, tdi_s, rst_s, sh_s, up_s, as_s, ds_s;
   logic in_shift, in_bus, in_next, done, clr;

   assign wr       = adr_ff[WriteBit];
   assign tck_rise = !tck_sync_ff[2] && tck_sync_ff[1];
   assign tdi_s    = tdi_sync_ff[2];
   assign rst_s    = reset_sync_ff[1];
   assign sh_s     = shift_sync_ff[2];
   assign up_s     = update_sync_ff[2];
   assign as_s     = adrsel_sync_ff[1];
   assign ds_s     = datasel_sync_ff[1];
   assign in_shift = (phase_ff == PH_SHIFT);
   assign in_bus   = (phase_ff == PH_BUS);
   assign in_next  = (phase_ff == PH_NEXT);
   assign done     = in_bus && req.dma_active && req.dma_ready;
   assign clr      = !req.bridge_reset_n || rst_s;

   // The word address wraps inside its window; bits outside it are kept.
   assign win_inc = adr_ff[IncWindowBits+1:2] + {{(IncWindowBits-1){1'b0}}, 1'b1};
   assign adr_inc = {adr_ff[AdrRegBits-1:IncWindowBits+2], win_inc, adr_ff[1:0]};

   always_comb begin
      rsp.tdo         = as_s ? adr_ff[0] : dat_ff[0];
      rsp.dma_address = adr_ff[BusBits-1:0];
      rsp.dma_wdata   = dat_ff[BusBits-1:0];
      rsp.dma_start   = in_bus && !req.dma_active;
      rsp.dma_write   = wr;
      rsp.dma_size    = in_shift ? 2'b00 : adr_ff[BusBits+1:BusBits];
   end

   always_comb begin
      phase_in = phase_ff;
      if (clr) begin
         phase_in = PH_SHIFT;
      end else if (in_shift && !sh_s && up_s && ((as_s && !wr) || (ds_s && (wr || seq_ff)))) begin
         phase_in = PH_BUS;
      end else if (done) begin
         phase_in = PH_NEXT;
      end else if (in_next && !up_s) begin
         phase_in = PH_SHIFT;
      end

      adr_in = adr_ff;
      if (clr) begin
         adr_in = '0;
      end else if (in_shift && as_s && tck_rise && sh_s) begin
         adr_in = {tdi_s, adr_ff[AdrRegBits-1:1]};
      end else if (in_shift && ds_s && up_s && seq_ff && !wr) begin
         adr_in = adr_inc;
      end else if (done && seq_ff && wr) begin
         adr_in = adr_inc;
      end

      dat_in = dat_ff;
      if (!req.bridge_reset_n) begin
         dat_in = '0;
      end else if (in_shift && ds_s && tck_rise && sh_s) begin
         dat_in = {tdi_s, dat_ff[DatRegBits-1:1]};
      end else if (in_shift && up_s) begin
         dat_in = {1'b0, dat_ff[BusBits-1:0]};
      end else if (done) begin
         dat_in = {1'b0, req.dma_rdata};
      end

      seq_in = seq_ff;
      if (clr) begin
         seq_in = 1'b0;
      end else if (in_shift && ds_s && tck_rise && sh_s) begin
         seq_in = tdi_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tck_sync_ff     <= '0;
         tdi_sync_ff     <= '0;
         shift_sync_ff   <= '0;
         update_sync_ff  <= '0;
         reset_sync_ff   <= '0;
         adrsel_sync_ff  <= '0;
         datasel_sync_ff <= '0;
         phase_ff        <= PH_SHIFT;
         adr_ff          <= '0;
         dat_ff          <= '0;
         seq_ff          <= 1'b0;
      end else if (accept) begin
         tck_sync_ff     <= {tck_sync_ff[1:0], req.tck};
         tdi_sync_ff     <= {tdi_sync_ff[1:0], req.tdi};
         shift_sync_ff   <= {shift_sync_ff[1:0], req.shift_dr};
         update_sync_ff  <= {update_sync_ff[1:0], req.update_dr};
         reset_sync_ff   <= {reset_sync_ff[0], req.tap_reset};
         adrsel_sync_ff  <= {adrsel_sync_ff[0], req.adr_sel};
         datasel_sync_ff <= {datasel_sync_ff[0], req.data_sel};
         phase_ff        <= phase_in;
         adr_ff          <= adr_in;
         dat_ff          <= dat_in;
         seq_ff          <= seq_in;
      end
   end

endmodule

// ===== hw/rtl/jtag_to_bus_dma_bridge.sv =====
// Top level of the JTAG to bus DMA bridge with its result register and skid stage.
//
// Each request is one system-clock sample of the raw TAP signals (TCK, TDI,
// shift, update, the two register selects and TAP reset) together with the
// DMA handshake inputs and read data. Each accepted request yields exactly
// one response carrying TDO and the DMA request outputs, computed from the
// bridge state as it stood before that sample was applied, with dma_start
// also looking at the sample's dma_active.
//
// Each response is registered in the response register or the skid register.
// Throughput is one request per cycle while req_stall is low; the bridge
// state is updated by a single pass of logic between the request and the
// response register, so nothing limits the rate but the response side.
//
// When the receiver stalls, the response register holds and one further
// request is taken into a skid register; req_stall rises only once that
// skid register is full, and falls as soon as the response moves on.
//
// The reset input clears the synchronisers, the phase sequencer, the
// address/command and data registers and both response stages. The sample
// field bridge_reset_n clears the phase, address/command and data registers
// and the synchronised TAP reset all but data, in the ordinary course of requests.
module jtag_to_bus_dma_bridge #(
   parameter int unsigned IncWindowBits = jtdb_pkg::IncWindowBitsDefault
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_bridge_reset_n,
   input  logic        req_tck,
   input  logic        req_tdi,
   input  logic        req_adr_sel,
   input  logic        req_data_sel,
   input  logic        req_shift_dr,
   input  logic        req_update_dr,
   input  logic        req_tap_reset,
   input  logic        req_dma_active,
   input  logic        req_dma_ready,
   input  logic [31:0] req_dma_rdata,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tdo,
   output logic [31:0] rsp_dma_address,
   output logic [31:0] rsp_dma_wdata,
   output logic        rsp_dma_start,
   output logic        rsp_dma_write,
   output logic [1:0]  rsp_dma_size
);
   import jtdb_pkg::*;

   req_type req;
   rsp_type rsp_new;
   rsp_type rsp_ff, skid_ff;
   logic    rsp_valid_ff, skid_valid_ff;
   logic    accept, rsp_take;

   assign req.bridge_reset_n = req_bridge_reset_n;
   assign req.tck            = req_tck;
   assign req.tdi            = req_tdi;
   assign req.adr_sel        = req_adr_sel;
   assign req.data_sel       = req_data_sel;
   assign req.shift_dr       = req_shift_dr;
   assign req.update_dr      = req_update_dr;
   assign req.tap_reset      = req_tap_reset;
   assign req.dma_active     = req_dma_active;
   assign req.dma_ready      = req_dma_ready;
   assign req.dma_rdata      = req_dma_rdata;

   // Requests are refused only while the skid register holds a response.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   jtdb_core #(
      .IncWindowBits(IncWindowBits)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req),
      .rsp   (rsp_new)
   );

   // Control of the two response stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (rsp_valid_ff && rsp_stall) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload of the two response stages; the skid register drains first.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_ff <= skid_ff;
         end
      end else if (accept) begin
         if (rsp_valid_ff && rsp_stall) begin
            skid_ff <= rsp_new;
         end else begin
            rsp_ff <= rsp_new;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tdo         = rsp_ff.tdo;
   assign rsp_dma_address = rsp_ff.dma_address;
   assign rsp_dma_wdata   = rsp_ff.dma_wdata;
   assign rsp_dma_start   = rsp_ff.dma_start;
   assign rsp_dma_write   = rsp_ff.dma_write;
   assign rsp_dma_size    = rsp_ff.dma_size;

endmodule

// ===== hw/rtl/jtdb_checker.sv =====
// Port-level checks for the JTAG to bus DMA bridge, bound to its top level.
module jtdb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_dma_address,
   input logic [31:0] rsp_dma_wdata
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_dma_address) && $stable(rsp_dma_wdata))
      else $error("response payload changed while stalled");

   // Every accepted request has a response waiting at the next edge.
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // The request side is held back only because the response side was stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // Nothing is offered straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response stages not empty after reset");

endmodule

bind jtag_to_bus_dma_bridge jtdb_checker u_jtdb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_dma_address(rsp_dma_address),
   .rsp_dma_wdata  (rsp_dma_wdata)
);
